/* rtl/core/nrwc_pkg.sv */
package nrwc_pkg;

    localparam int ENTRIES   = 64;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int NONCE_W   = 256;
    localparam int STAMP_W   = 48;
    localparam int CAP_W     = 7;
    localparam int ROW_W     = NONCE_W + STAMP_W;
    localparam int IN_DATA_W = 312;
    localparam int OUT_DATA_W = 16;

    localparam logic [1:0] CMD_CHECK_ADD = 2'd0;
    localparam logic [1:0] CMD_CONTAINS  = 2'd1;
    localparam logic [1:0] CMD_PRUNE     = 2'd2;

    localparam logic CFG_EXPIRY = 1'b0;
    localparam logic CFG_MAXENT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_EVICT,
        ST_LK_RD,
        ST_LK_CHK,
        ST_APPEND,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/nrwc_ram.sv */
module nrwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/nonce_replay_window_cache.sv */
// Anti-replay nonce cache with time expiry.
// s_axis beat: cmd, a 256-bit nonce and the current tick. m_axis beat: hit,
// added and occupancy. cfg writes set expiry_window (index 0) and max_entries
// (index 1); the user must write them only while idle, the block does not enforce it.
// The entries sit in a 64-row RAM used as a ring; one sequencer walks it
// through a single registered read port, one row at a time, reading then checking it.
// A check-and-add expires stale entries from the oldest end, evicts the oldest
// while the cache is at max_entries, compares the nonce with the stored entries
// through the single 256-bit compare until a match, and appends it on a miss; a
// prune only expires, and a contains only compares.
// s_axis_tready is high only when the sequencer is idle and the output
// register is empty or being taken. A stalled m_axis holds the result and
// the block accepts nothing new until it is taken.
// Reset empties the ring (count and oldest pointer), restores the register
// defaults; RAM contents need no clearing.
module nonce_replay_window_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], nonce_w0..w3[257:2], now_ticks[305:258], zero pad
    input  logic [nrwc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: hit[0], added[1], occupancy[8:2], zero pad
    output logic [nrwc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data
);
    import nrwc_pkg::*;

    state_t state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [NONCE_W-1:0] nonce_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [STAMP_W-1:0] win_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [SLOT_W-1:0]  oldest_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] k_reg;
    logic               hit_reg, added_reg, ovalid_reg;
    logic [CAP_W-1:0]   occ_reg;

    logic [ROW_W-1:0]   rdata;
    logic [SLOT_W-1:0]  raddr, waddr;
    logic               we;
    logic [COUNT_W-1:0] cap_eff;
    logic               expired, match, out_free;

    assign cfg_ready     = 1'b1;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, occ_reg, added_reg, hit_reg};

    assign cap_eff = (cap_reg > CAP_W'(ENTRIES)) ? COUNT_W'(ENTRIES) : COUNT_W'(cap_reg);
    // stamp + window < now, with carry
    assign expired = ({1'b0, rdata[ROW_W-1:NONCE_W]} + {1'b0, win_reg})
                     < {1'b0, now_reg};
    assign match   = rdata[NONCE_W-1:0] == nonce_reg;

    assign raddr = (state_reg == ST_EXP_RD) ? oldest_reg
                 : SLOT_W'(oldest_reg + SLOT_W'(k_reg));
    assign waddr = SLOT_W'(oldest_reg + SLOT_W'(count_reg));
    assign we    = (state_reg == ST_APPEND);

    nrwc_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({now_reg, nonce_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    case (s_axis_tdata[1:0])
                        CMD_CHECK_ADD, CMD_PRUNE: state_next = ST_EXP_RD;
                        CMD_CONTAINS:             state_next = ST_LK_RD;
                        default:                  state_next = ST_DONE;
                    endcase
                end
            ST_EXP_RD:
                state_next = (count_reg == '0) ? ST_EVICT : ST_EXP_CHK;
            ST_EXP_CHK:
                if (!expired)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_EXP_RD;
                end
            ST_EVICT:
                if (cmd_reg == CMD_PRUNE)
                begin
                    state_next = ST_DONE;
                end
                else if (!(count_reg != '0 && count_reg >= cap_eff))
                begin
                    state_next = ST_LK_RD;
                end
            ST_LK_RD:
                if (k_reg >= count_reg)
                begin
                    state_next = (cmd_reg == CMD_CHECK_ADD) ? ST_APPEND : ST_DONE;
                end
                else
                begin
                    state_next = ST_LK_CHK;
                end
            ST_LK_CHK:
                state_next = match ? ST_DONE : ST_LK_RD;
            ST_APPEND: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            win_reg    <= STAMP_W'(3600);
            cap_reg    <= CAP_W'(64);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == CFG_EXPIRY)
            begin
                win_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_MAXENT)
            begin
                cap_reg <= cfg_data[CAP_W-1:0];
            end
            // pop on expiry or eviction
            if ((state_reg == ST_EXP_CHK && expired) ||
                (state_reg == ST_EVICT && cmd_reg != CMD_PRUNE &&
                 count_reg != '0 && count_reg >= cap_eff))
            begin
                oldest_reg <= SLOT_W'(oldest_reg + 1'b1);
                count_reg  <= count_reg - 1'b1;
            end
            if (we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_DONE)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tdata[1:0];
            nonce_reg <= s_axis_tdata[257:2];
            now_reg   <= s_axis_tdata[305:258];
            hit_reg   <= 1'b0;
            added_reg <= 1'b0;
            k_reg     <= '0;
        end
        if (state_reg == ST_LK_RD && k_reg < count_reg)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (state_reg == ST_LK_CHK && match)
        begin
            hit_reg <= 1'b1;
        end
        if (we)
        begin
            added_reg <= 1'b1;
        end
        if (state_reg == ST_DONE)
        begin
            occ_reg <= CAP_W'(count_reg);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(ENTRIES))
        else $error("count over capacity");
    a_hit_added: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(hit_reg && added_reg))
        else $error("hit and added together");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");

endmodule

/* test/nonce_replay_window_cache_tb.sv */
module nonce_replay_window_cache_tb;
    import nrwc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic       hit;
        logic       added;
        logic [6:0] occ;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [47:0] cfg_data;

    nonce_replay_window_cache i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the cache ring and its registers
    logic [255:0] shadow_nonce [ENTRIES];
    logic [47:0]  shadow_stamp [ENTRIES];
    int           shadow_head;
    int           shadow_count;
    logic [47:0]  shadow_window;
    logic [6:0]   shadow_cap;

    verdict_t     pending_verdicts [$];
    logic [255:0] seen_nonces [$];
    logic [47:0]  tick;
    int           fail_count;
    int           items_sent;
    int           hits_seen;
    int           adds_seen;
    bit           quiet;
    int           hold_cycles;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        #60000000;
        $display("timeout at %0t, %0d results outstanding", $time, pending_verdicts.size());
        $display("** nonce_replay_window_cache: FAILED **");
        $finish;
    end

    function automatic logic [255:0] rand_nonce();
        logic [255:0] n;
        for (int i = 0; i < 8; i++)
            n[i*32 +: 32] = $urandom;
        return n;
    endfunction

    function automatic bit shadow_lookup(input logic [255:0] n);
        for (int k = 0; k < shadow_count; k++)
            if (shadow_nonce[(shadow_head + k) % ENTRIES] == n)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic shadow_pop();
        if (shadow_count > 0)
        begin
            shadow_head  = (shadow_head + 1) % ENTRIES;
            shadow_count = shadow_count - 1;
        end
    endtask

    task automatic shadow_expire(input logic [47:0] now);
        while (shadow_count > 0 &&
               ({1'b0, shadow_stamp[shadow_head]} + {1'b0, shadow_window}) < {1'b0, now})
            shadow_pop();
    endtask

    // Compute the verdict of one command and advance the shadow state
    task automatic cache_apply(input logic [1:0] cmd, input logic [255:0] n,
                               input logic [47:0] now, output verdict_t v);
        int cap;
        int s;
        v = '0;
        cap = (shadow_cap > ENTRIES) ? ENTRIES : shadow_cap;
        case (cmd)
            CMD_CHECK_ADD:
            begin
                shadow_expire(now);
                while (shadow_count > 0 && shadow_count >= cap)
                    shadow_pop();
                if (shadow_lookup(n))
                    v.hit = 1'b1;
                else
                begin
                    s = (shadow_head + shadow_count) % ENTRIES;
                    shadow_nonce[s] = n;
                    shadow_stamp[s] = now;
                    shadow_count = shadow_count + 1;
                    v.added = 1'b1;
                end
            end
            CMD_CONTAINS: v.hit = shadow_lookup(n);
            CMD_PRUNE:    shadow_expire(now);
            default: ;
        endcase
        v.occ = shadow_count[6:0];
    endtask

    // Send one beat, with random gaps before it
    task automatic send_item(input logic [1:0] cmd, input logic [255:0] n,
                             input logic [47:0] now);
        verdict_t v;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {IN_DATA_W{1'($urandom_range(1))}};
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, now, n, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        cache_apply(cmd, n, now, v);
        pending_verdicts.insert(pending_verdicts.size(), v);
        items_sent++;
        seen_nonces.insert(seen_nonces.size(), n);
        if (seen_nonces.size() > 160)
            void'(seen_nonces.pop_front());
    endtask

    // Wait for every verdict, then let the sequencer settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_EXPIRY)
            shadow_window = value;
        else
            shadow_cap = value[6:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pick a nonce: half the time one already seen, so lookups hit
    function automatic logic [255:0] pick_nonce();
        if (seen_nonces.size() > 0 && $urandom_range(99) < 50)
            return seen_nonces[$urandom_range(seen_nonces.size() - 1)];
        return rand_nonce();
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 60) return CMD_CHECK_ADD;
        if (r < 82) return CMD_CONTAINS;
        if (r < 96) return CMD_PRUNE;
        return CMD_UNUSED;
    endfunction

    // Advance time by a random step of up to span, saturating at the top
    task automatic advance_tick(input logic [47:0] span);
        logic [48:0] next;
        next = {1'b0, tick} + 49'($urandom_range(32'(span), 0));
        tick = next[48] ? TICK_MAX : next[47:0];
    endtask

    // Receiver: random stalls, long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
            m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // Check each result against the oldest verdict
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== v.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, v.hit, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[1] !== v.added)
                begin
                    $display("%0t: added expected %b actual %b", $time, v.added,
                             m_axis_tdata[1]);
                    fail_count++;
                end
                if (m_axis_tdata[8:2] !== v.occ)
                begin
                    $display("%0t: occupancy expected %0d actual %0d", $time, v.occ,
                             m_axis_tdata[8:2]);
                    fail_count++;
                end
                hits_seen += v.hit;
                adds_seen += v.added;
            end
        end
    end

    // Field extremes, every command, replay and backward ticks
    task automatic test_directed();
        logic [255:0] a;
        logic [255:0] b;
        a = rand_nonce();
        b = rand_nonce();
        send_item(CMD_CONTAINS, '0, 48'd0);
        send_item(CMD_CHECK_ADD, '0, 48'd0);
        send_item(CMD_CHECK_ADD, '1, 48'd5);
        send_item(CMD_CHECK_ADD, '0, 48'd6);
        send_item(CMD_CONTAINS, '1, 48'd6);
        send_item(CMD_PRUNE, '1, 48'd7);
        send_item(CMD_UNUSED, '1, 48'd7);
        write_reg(CFG_EXPIRY, 48'd10);
        send_item(CMD_CHECK_ADD, a, 48'd100);
        send_item(CMD_CHECK_ADD, b, 48'd50);
        send_item(CMD_PRUNE, '0, 48'd70);
        send_item(CMD_CONTAINS, b, 48'd70);
        send_item(CMD_PRUNE, '0, 48'd200);
        send_item(CMD_CHECK_ADD, a, 48'd200);
        send_item(CMD_CHECK_ADD, a, 48'd210);
        send_item(CMD_CHECK_ADD, a, 48'd211);
        tick = 48'd211;
    endtask

    // Capacity of one, zero and above the ring size
    task automatic test_capacity_limits();
        logic [47:0] caps [4];
        caps = '{48'd1, 48'd0, 48'd100, 48'd127};
        write_reg(CFG_EXPIRY, TICK_MAX);
        foreach (caps[c])
        begin
            write_reg(CFG_MAXENT, caps[c]);
            repeat (70)
            begin
                advance_tick(3);
                send_item($urandom_range(99) < 80 ? CMD_CHECK_ADD : CMD_CONTAINS,
                          pick_nonce(), tick);
            end
        end
    endtask

    // Zero window and ticks near the top of the range
    task automatic test_window_extremes();
        write_reg(CFG_MAXENT, 48'd64);
        write_reg(CFG_EXPIRY, 48'd0);
        repeat (40)
        begin
            advance_tick(2);
            send_item(pick_cmd(), pick_nonce(), tick);
        end
        write_reg(CFG_EXPIRY, 48'd3600);
        tick = TICK_MAX - 48'd5000;
        repeat (60)
        begin
            advance_tick(200);
            send_item(pick_cmd(), pick_nonce(), tick);
        end
    endtask

    // Hold the receiver off while items keep coming
    task automatic test_backpressure();
        drain();
        tick = 48'd1000;
        write_reg(CFG_EXPIRY, 48'd500);
        hold_cycles = 600;
        repeat (12)
        begin
            advance_tick(20);
            send_item(CMD_CHECK_ADD, pick_nonce(), tick);
        end
    endtask

    // Random traffic over several window and capacity settings
    task automatic test_random_traffic();
        logic [47:0] windows [4];
        logic [47:0] caps [4];
        windows = '{48'd3600, 48'd40, 48'd300, TICK_MAX};
        caps    = '{48'd64, 48'd8, 48'd33, 48'd64};
        drain();
        tick = 48'd0;
        foreach (windows[p])
        begin
            write_reg(CFG_EXPIRY, windows[p]);
            write_reg(CFG_MAXENT, caps[p]);
            quiet = (p == 1);
            repeat (400)
            begin
                advance_tick((windows[p] > 48'd2000) ? 48'd60 : windows[p] / 6 + 1);
                send_item(pick_cmd(), pick_nonce(), tick);
            end
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_EXPIRY;
        cfg_data      = '0;
        fail_count    = 0;
        items_sent    = 0;
        hits_seen     = 0;
        adds_seen     = 0;
        quiet         = 1'b0;
        hold_cycles   = 0;
        tick          = '0;
        shadow_head   = 0;
        shadow_count  = 0;
        shadow_window = 48'd3600;
        shadow_cap    = 7'd64;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_capacity_limits();
        test_window_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (300) @(posedge clk);

        $display("covered %0d commands (%0d replays seen, %0d nonces stored)",
                 items_sent, hits_seen, adds_seen);
        $display("over window and capacity extremes, backward ticks and a long output stall");
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("** nonce_replay_window_cache: PASSED **");
        else
            $display("** nonce_replay_window_cache: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/nrwc_pkg.sv
rtl/core/nrwc_ram.sv
rtl/core/nonce_replay_window_cache.sv
test/nonce_replay_window_cache_tb.sv
